// ----- rtl/pbt_pkg.sv -----
// shared types, codes and the base classifier for the pileup base tally
// no dependencies
`default_nettype none
package pbt_pkg;

    localparam int MAX_DEPTH_DEF  = 4096;
    localparam int INDEL_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CNT_W          = 13;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_BASES = 2'd0,
        FUNC_QUAL  = 2'd1,
        FUNC_END   = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_COUNT   = 3'd1,
        ST_BAD_INDEL  = 3'd2,
        ST_TRUNC      = 3'd3,
        ST_DEPTH      = 3'd4,
        ST_QUAL       = 3'd5,
        ST_BAD_ALLELE = 3'd6,
        ST_OVERFLOW   = 3'd7
    } status_t;

    localparam logic [2:0] CLS_A      = 3'd0;
    localparam logic [2:0] CLS_C      = 3'd1;
    localparam logic [2:0] CLS_G      = 3'd2;
    localparam logic [2:0] CLS_T      = 3'd3;
    localparam logic [2:0] CLS_N      = 3'd4;
    localparam logic [2:0] CLS_DEL    = 3'd5;
    localparam logic [2:0] CLS_IGNORE = 3'd6;
    localparam logic [2:0] CLS_BAD    = 3'd7;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_N      = 8'h4E;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_QUAL  = 2'd1,
        OP_END   = 2'd2,
        OP_FLAG  = 2'd3
    } op_kind_t;

    // one classified request between the parser and the tally side
    typedef struct packed {
        op_kind_t    kind;
        logic [2:0]  cls;
        logic        pass;
        status_t     flag;
        logic [15:0] depth;
    } op_t;

    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [7:0] u;
        logic [2:0] r;
        u = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - 8'd32 : c;
        unique case (u)
            CH_A:            r = CLS_A;
            CH_C:            r = CLS_C;
            CH_G:            r = CLS_G;
            CH_T:            r = CLS_T;
            CH_N:            r = CLS_N;
            CH_STAR, CH_HASH: r = CLS_DEL;
            CH_LT, CH_GT:    r = CLS_IGNORE;
            default:         r = CLS_BAD;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pileup_base_tally.sv -----
// top level of the pileup base tally: config registers, parser, queue, tally side
// depends on pbt_pkg, pbt_front, pbt_queue, pbt_back
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid / in_stall  | func, in_byte, ref_base, declared_depth
//   out     | source    | out_valid / out_stall| count_a..count_del, base_total, status
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one byte is accepted per cycle while the queue has room; the parser feeds a
// four-entry request queue and the tally side retires one request per cycle,
// when out_stall does not hold it, through a two-stage pipe (store access, then
// counter update); the result register follows the pipe. reset clears all
// control state; the base store needs no clearing. out_stall only holds the tally
// side while a finished result waits, and input stalls once the queue fills behind it.
`default_nettype none
module pileup_base_tally
    import pbt_pkg::*;
#(
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
    parameter int INDEL_BITS = INDEL_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        func,
    input  wire logic [7:0]        in_byte,
    input  wire logic [7:0]        ref_base,
    input  wire logic [15:0]       declared_depth,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CNT_W-1:0]       count_a,
    output logic [CNT_W-1:0]       count_c,
    output logic [CNT_W-1:0]       count_g,
    output logic [CNT_W-1:0]       count_t,
    output logic [CNT_W-1:0]       count_n,
    output logic [CNT_W-1:0]       count_del,
    output logic [CNT_W-1:0]       base_total,
    output logic [2:0]             status,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [6:0]        cfg_data
);

    localparam logic [1:0] REG_STRICT   = 2'd0;
    localparam logic [1:0] REG_QUAL_ON  = 2'd1;
    localparam logic [1:0] REG_MIN_QUAL = 2'd2;
    localparam logic [1:0] REG_Q_OFFSET = 2'd3;

    logic       strict_reg;
    logic       qual_on_reg;
    logic [6:0] min_qual_reg;
    logic [6:0] q_offset_reg;

    logic accept;
    logic q_full;
    logic push;
    op_t  push_op;
    logic q_valid;
    op_t  q_op;
    logic q_pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg   <= 1'b0;
            qual_on_reg  <= 1'b1;
            min_qual_reg <= 7'd0;
            q_offset_reg <= 7'd33;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STRICT:   strict_reg   <= cfg_data[0];
                REG_QUAL_ON:  qual_on_reg  <= cfg_data[0];
                REG_MIN_QUAL: min_qual_reg <= cfg_data;
                REG_Q_OFFSET: q_offset_reg <= cfg_data;
                default:      strict_reg   <= strict_reg;
            endcase
        end
    end

    pbt_front #(
        .INDEL_BITS(INDEL_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .func           (func),
        .in_byte        (in_byte),
        .ref_base       (ref_base),
        .declared_depth (declared_depth),
        .strict_mode    (strict_reg),
        .quality_present(qual_on_reg),
        .min_quality    (min_qual_reg),
        .quality_offset (q_offset_reg),
        .push           (push),
        .op             (push_op)
    );

    pbt_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .din  (push_op),
        .full (q_full),
        .pop  (q_pop),
        .valid(q_valid),
        .dout (q_op)
    );

    pbt_back #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_op           (q_op),
        .q_pop          (q_pop),
        .quality_present(qual_on_reg),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .count_a        (count_a),
        .count_c        (count_c),
        .count_g        (count_g),
        .count_t        (count_t),
        .count_n        (count_n),
        .count_del      (count_del),
        .base_total     (base_total),
        .status         (status)
    );

endmodule
`default_nettype wire

// ----- rtl/pbt_front.sv -----
// byte parser: indel/caret skipping, base classification, quality screening
// depends on pbt_pkg
`default_nettype none
module pbt_front
    import pbt_pkg::*;
#(
    parameter int INDEL_BITS = INDEL_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  in_byte,
    input  wire logic [7:0]  ref_base,
    input  wire logic [15:0] declared_depth,
    input  wire logic        strict_mode,
    input  wire logic        quality_present,
    input  wire logic [6:0]  min_quality,
    input  wire logic [6:0]  quality_offset,
    output logic             push,
    output op_t              op
);

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_SIGN   = 5'b00010,
        MODE_DIGITS = 5'b00100,
        MODE_SKIP   = 5'b01000,
        MODE_CARET  = 5'b10000
    } mode_t;

    localparam logic [INDEL_BITS-1:0] LIM = {INDEL_BITS{1'b1}};

    mode_t                  mode_reg, mode_next;
    logic [INDEL_BITS-1:0]  rem_reg, rem_next;
    logic [INDEL_BITS-1:0]  rem_dec;
    logic [INDEL_BITS+3:0]  prod;
    logic [3:0]             digit_val;
    logic                   digit_hit;
    logic                   do_norm;
    logic                   do_skip;
    logic                   do_store;
    logic [2:0]             store_cls;
    status_t                flag;
    logic [8:0]             qual_floor;

    assign digit_hit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit_val = in_byte[3:0];
    assign rem_dec   = rem_reg - INDEL_BITS'(1);
    assign prod      = ({4'd0, rem_reg} << 3) + ({4'd0, rem_reg} << 1)
                     + {{INDEL_BITS{1'b0}}, digit_val};
    assign qual_floor = {2'd0, quality_offset} + {2'd0, min_quality};

    always_comb
    begin
        mode_next = mode_reg;
        rem_next  = rem_reg;
        do_norm   = 1'b0;
        do_skip   = 1'b0;
        do_store  = 1'b0;
        store_cls = CLS_BAD;
        flag      = ST_OK;
        push      = 1'b0;
        op        = '0;
        op.depth  = declared_depth;
        if (accept)
        begin
            unique case (func_t'(func))
                FUNC_BASES:
                begin
                    unique case (mode_reg)
                        MODE_SIGN:
                        begin
                            if (digit_hit)
                            begin
                                rem_next  = INDEL_BITS'(digit_val);
                                mode_next = MODE_DIGITS;
                            end
                            else
                            begin
                                flag      = ST_NO_COUNT;
                                mode_next = MODE_NORMAL;
                                do_norm   = 1'b1;
                            end
                        end
                        MODE_DIGITS:
                        begin
                            if (digit_hit)
                            begin
                                if (prod > {4'd0, LIM})
                                begin
                                    flag     = ST_NO_COUNT;
                                    rem_next = LIM;
                                end
                                else
                                begin
                                    rem_next = prod[INDEL_BITS-1:0];
                                end
                            end
                            else if (rem_reg == '0)
                            begin
                                mode_next = MODE_NORMAL;
                                do_norm   = 1'b1;
                            end
                            else
                            begin
                                do_skip = 1'b1;
                            end
                        end
                        MODE_SKIP:
                        begin
                            if (rem_reg == '0)
                            begin
                                mode_next = MODE_NORMAL;
                                do_norm   = 1'b1;
                            end
                            else
                            begin
                                do_skip = 1'b1;
                            end
                        end
                        MODE_CARET:
                        begin
                            mode_next = MODE_NORMAL;
                        end
                        default:
                        begin
                            mode_next = MODE_NORMAL;
                            do_norm   = 1'b1;
                        end
                    endcase

                    if (do_skip)
                    begin
                        if (strict_mode && (classify(in_byte) >= CLS_IGNORE))
                        begin
                            flag = ST_BAD_INDEL;
                        end
                        rem_next  = rem_dec;
                        mode_next = (rem_dec == '0) ? MODE_NORMAL : MODE_SKIP;
                    end

                    if (do_norm)
                    begin
                        case (in_byte)
                            CH_PLUS, CH_MINUS:
                            begin
                                mode_next = MODE_SIGN;
                                rem_next  = '0;
                            end
                            CH_CARET:
                            begin
                                mode_next = MODE_CARET;
                            end
                            CH_DOLLAR:
                            begin
                                mode_next = MODE_NORMAL;
                            end
                            CH_DOT, CH_COMMA:
                            begin
                                do_store  = 1'b1;
                                store_cls = classify(ref_base);
                            end
                            default:
                            begin
                                do_store  = 1'b1;
                                store_cls = classify(in_byte);
                            end
                        endcase
                    end

                    op.kind = do_store ? OP_STORE : OP_FLAG;
                    op.cls  = store_cls;
                    op.flag = flag;
                    push    = do_store || (flag != ST_OK);
                end
                FUNC_QUAL:
                begin
                    op.kind = OP_QUAL;
                    op.pass = (min_quality == 7'd0) || ({1'b0, in_byte} >= qual_floor);
                    push    = quality_present;
                end
                FUNC_END:
                begin
                    if (mode_reg == MODE_SIGN)
                    begin
                        flag = ST_NO_COUNT;
                    end
                    else if (mode_reg == MODE_CARET ||
                             ((mode_reg == MODE_DIGITS || mode_reg == MODE_SKIP) &&
                              rem_reg != '0))
                    begin
                        flag = ST_TRUNC;
                    end
                    op.kind   = OP_END;
                    op.flag   = flag;
                    push      = 1'b1;
                    mode_next = MODE_NORMAL;
                    rem_next  = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            rem_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            rem_reg  <= rem_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pbt_queue.sv -----
// small request queue between the parser and the tally side
// depends on pbt_pkg
`default_nettype none
module pbt_queue
    import pbt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       din,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output op_t       dout
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    op_t          slot_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QW:0]   fill_reg, fill_next;

    assign full  = (fill_reg == (QW+1)'(QUEUE_DEPTH));
    assign valid = (fill_reg != '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (QW+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QW'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pbt_back.sv -----
// base store, quality tally, end-of-sample checks and result register
// depends on pbt_pkg
`default_nettype none
module pbt_back
    import pbt_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  op_t                    q_op,
    output logic                   q_pop,
    input  wire logic              quality_present,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic [CNT_W-1:0]       count_a,
    output logic [CNT_W-1:0]       count_c,
    output logic [CNT_W-1:0]       count_g,
    output logic [CNT_W-1:0]       count_t,
    output logic [CNT_W-1:0]       count_n,
    output logic [CNT_W-1:0]       count_del,
    output logic [CNT_W-1:0]       base_total,
    output logic [2:0]             status
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int AW = $clog2(MAX_DEPTH);
    localparam int DW = (CW > 16) ? CW : 16;
    localparam int SW = ((CW > CNT_W) ? CW : CNT_W) + 1;

    // stage 1 state
    logic [CW-1:0]    bcount_reg, bcount_next;
    logic [CW-1:0]    qpos_reg, qpos_next;
    logic [CW-1:0]    scnt_reg [6];
    logic [CW-1:0]    scnt_next [6];
    logic             sbad_reg, sbad_next;
    logic [2:0]       mem [MAX_DEPTH];

    // stage 2 state
    logic             s2_valid_reg;
    op_kind_t         s2_kind_reg;
    status_t          s2_flag_reg;
    logic             s2_tally_reg;
    logic [CW-1:0]    s2_add_reg [6];
    logic             s2_bad_reg;
    logic [CNT_W-1:0] s2_total_reg;
    logic [2:0]       rdata_reg;

    logic [CNT_W-1:0] cnt_reg [6];
    logic [CNT_W-1:0] cnt_next [6];
    status_t          err_reg, err_next;

    logic             out_valid_reg;
    logic [CNT_W-1:0] out_cnt_reg [6];
    logic [CNT_W-1:0] out_total_reg;
    status_t          out_status_reg;

    logic             adv;
    logic             take;
    logic             wr_en;
    logic             rd_en;
    status_t          loc_flag;
    status_t          s1_flag;
    logic             s1_bad;
    logic [CW-1:0]    s1_add [6];
    logic [CNT_W-1:0] s1_total;
    logic             s2_go;
    logic             s2_end;
    status_t          err_after;
    logic             tally_bad;
    logic [SW-1:0]    fin_sum [6];
    logic [CNT_W-1:0] fin_cnt [6];
    status_t          fin_err;

    // only a finished sample waiting on a full result register holds the back end
    assign adv    = !(s2_valid_reg && s2_kind_reg == OP_END && out_valid_reg && out_stall);
    assign take   = q_valid && adv;
    assign q_pop  = take;
    assign s2_go  = s2_valid_reg && adv;
    assign s2_end = s2_go && (s2_kind_reg == OP_END);
    assign s1_total = (SW'(bcount_reg) > SW'(CNT_MAX)) ? CNT_MAX : bcount_reg[CNT_W-1:0];

    always_comb
    begin
        bcount_next = bcount_reg;
        qpos_next   = qpos_reg;
        scnt_next   = scnt_reg;
        sbad_next   = sbad_reg;
        loc_flag    = ST_OK;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        s1_bad      = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            s1_add[i] = '0;
        end
        if (take)
        begin
            unique case (q_op.kind)
                OP_STORE:
                begin
                    if (bcount_reg >= CW'(MAX_DEPTH))
                    begin
                        loc_flag = ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        bcount_next = bcount_reg + CW'(1);
                        for (int i = 0; i < 6; i++)
                        begin
                            if (q_op.cls == 3'(i))
                            begin
                                scnt_next[i] = scnt_reg[i] + CW'(1);
                            end
                        end
                        if (q_op.cls == CLS_BAD)
                        begin
                            sbad_next = 1'b1;
                        end
                    end
                end
                OP_QUAL:
                begin
                    if (qpos_reg >= bcount_reg)
                    begin
                        loc_flag = ST_QUAL;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        qpos_next = qpos_reg + CW'(1);
                    end
                end
                OP_END:
                begin
                    if (DW'(bcount_reg) != DW'(q_op.depth) &&
                        !(q_op.depth == 16'd0 && bcount_reg == CW'(1)))
                    begin
                        loc_flag = ST_DEPTH;
                    end
                    else if (quality_present && qpos_reg != bcount_reg)
                    begin
                        loc_flag = ST_QUAL;
                    end
                    // without qualities the stored bases are tallied at the end, all but ignored and bad ones
                    if (!quality_present)
                    begin
                        s1_add = scnt_reg;
                        s1_bad = sbad_reg;
                    end
                    bcount_next = '0;
                    qpos_next   = '0;
                    sbad_next   = 1'b0;
                    for (int i = 0; i < 6; i++)
                    begin
                        scnt_next[i] = '0;
                    end
                end
                default:
                begin
                    loc_flag = ST_OK;
                end
            endcase
        end
        s1_flag = (q_op.flag != ST_OK) ? q_op.flag : loc_flag;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[bcount_reg[AW-1:0]] <= q_op.cls;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[qpos_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg  <= q_op.kind;
            s2_flag_reg  <= s1_flag;
            s2_tally_reg <= rd_en && q_op.pass;
            s2_add_reg   <= s1_add;
            s2_bad_reg   <= s1_bad;
            s2_total_reg <= s1_total;
        end
        if (s2_end)
        begin
            out_cnt_reg    <= fin_cnt;
            out_total_reg  <= s2_total_reg;
            out_status_reg <= fin_err;
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        tally_bad = 1'b0;
        err_after = (err_reg != ST_OK) ? err_reg : s2_flag_reg;
        for (int i = 0; i < 6; i++)
        begin
            fin_sum[i] = SW'(cnt_reg[i]) + SW'(s2_add_reg[i]);
            fin_cnt[i] = (fin_sum[i] > SW'(CNT_MAX)) ? CNT_MAX : fin_sum[i][CNT_W-1:0];
        end
        fin_err = (err_after != ST_OK) ? err_after :
                  (s2_bad_reg ? ST_BAD_ALLELE : ST_OK);
        if (s2_go)
        begin
            err_next = err_after;
            if (s2_kind_reg == OP_QUAL && s2_tally_reg)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    if (rdata_reg == 3'(i) && cnt_reg[i] != CNT_MAX)
                    begin
                        cnt_next[i] = cnt_reg[i] + CNT_W'(1);
                    end
                end
                tally_bad = (rdata_reg == CLS_BAD);
                if (err_after == ST_OK && tally_bad)
                begin
                    err_next = ST_BAD_ALLELE;
                end
            end
            if (s2_kind_reg == OP_END)
            begin
                err_next = ST_OK;
                for (int i = 0; i < 6; i++)
                begin
                    cnt_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg    <= '0;
            qpos_reg      <= '0;
            sbad_reg      <= 1'b0;
            s2_valid_reg  <= 1'b0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                scnt_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            bcount_reg <= bcount_next;
            qpos_reg   <= qpos_next;
            scnt_reg   <= scnt_next;
            sbad_reg   <= sbad_next;
            cnt_reg    <= cnt_next;
            err_reg    <= err_next;
            if (adv)
            begin
                s2_valid_reg <= take;
            end
            if (s2_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign count_a    = out_cnt_reg[0];
    assign count_c    = out_cnt_reg[1];
    assign count_g    = out_cnt_reg[2];
    assign count_t    = out_cnt_reg[3];
    assign count_n    = out_cnt_reg[4];
    assign count_del  = out_cnt_reg[5];
    assign base_total = out_total_reg;
    assign status     = out_status_reg;

endmodule
`default_nettype wire

// ----- rtl/pbt_checker.sv -----
// port-level checks on the pileup base tally, bound to the top level
// depends on pbt_pkg and pileup_base_tally
`default_nettype none
module pbt_checker
    import pbt_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [CNT_W-1:0] count_a,
    input wire logic [CNT_W-1:0] count_c,
    input wire logic [CNT_W-1:0] count_g,
    input wire logic [CNT_W-1:0] count_t,
    input wire logic [CNT_W-1:0] count_n,
    input wire logic [CNT_W-1:0] count_del,
    input wire logic [CNT_W-1:0] base_total,
    input wire logic [2:0]       status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(base_total)
        && $stable(count_a) && $stable(count_del))
        else $error("stalled result changed");

    // nothing stored means nothing can be counted
    a_empty_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && base_total == '0 |-> count_a == '0 && count_c == '0 &&
        count_g == '0 && count_t == '0 && count_n == '0 && count_del == '0)
        else $error("counts without stored bases");

    // a bad allele comes only from a stored base
    a_bad_allele: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BAD_ALLELE |-> base_total != '0)
        else $error("bad allele with empty store");

endmodule

bind pileup_base_tally pbt_checker u_pbt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count_a   (count_a),
    .count_c   (count_c),
    .count_g   (count_g),
    .count_t   (count_t),
    .count_n   (count_n),
    .count_del (count_del),
    .base_total(base_total),
    .status    (status)
);
`default_nettype wire
